[rtl/core/assert_macros.svh]
// Assertion macros for the RTL files; vector_refraction includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/vref_pkg.sv]
// Package with types, constants and helpers of the vector refraction pipeline.
`default_nettype none
package vref_pkg;

  localparam int FRAC     = 16;
  localparam int VEC_W    = FRAC + 2;
  localparam int IDX_W    = 15;
  localparam int PROD_W   = 2 * VEC_W;
  localparam int QUO_W    = 21;
  localparam int REM_W    = 15;
  localparam int RAD_W    = 34;
  localparam int SREM_W   = 18;
  localparam int ROOT_W   = 17;
  localparam int WIDE_W   = 24;
  localparam int IN_W     = 128;
  localparam int OUT_W    = 56;

  localparam logic [IDX_W-1:0] IDX_ONE = 15'd4096;
  localparam logic signed [WIDE_W-1:0] ONE_Q = 24'sd65536;

  // Stage indexes of the pipeline.
  localparam int ST_PROD_IN = 0;
  localparam int ST_DOT     = 1;
  localparam int ST_PROD_D  = 2;
  localparam int ST_DIV_SET = 3;
  localparam int ST_DIV0    = 4;
  localparam int DIV_STEPS  = QUO_W;
  localparam int ST_TVAL    = ST_DIV0 + DIV_STEPS;
  localparam int ST_PROD_T  = ST_TVAL + 1;
  localparam int ST_RAD     = ST_PROD_T + 1;
  localparam int ST_SQ0     = ST_RAD + 1;
  localparam int SQ_STEPS   = ROOT_W;
  localparam int ST_PROD_Q  = ST_SQ0 + SQ_STEPS;
  localparam int ST_OUT     = ST_PROD_Q + 1;
  localparam int NST        = ST_OUT + 1;

  typedef struct packed {
    logic [2:0][VEC_W-1:0]  iv;
    logic [2:0][VEC_W-1:0]  nv;
    logic [IDX_W-1:0]       k;
    logic [2:0][PROD_W-1:0] prod;
    logic [VEC_W-1:0]       d;
    logic [2:0]             neg;
    logic [2:0][REM_W-1:0]  rem;
    logic [2:0][QUO_W-1:0]  num;
    logic [2:0][QUO_W-1:0]  quo;
    logic [2:0][VEC_W-1:0]  t;
    logic                   tir;
    logic [RAD_W-1:0]       rad;
    logic [SREM_W-1:0]      srem;
    logic [ROOT_W-1:0]      root;
  } item_t;

  function automatic logic [VEC_W-1:0] sat_vec(input logic signed [WIDE_W-1:0] x);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = 24'sd131071;
    lo = -24'sd131072;
    if (x > hi) begin
      sat_vec = hi[VEC_W-1:0];
    end else if (x < lo) begin
      sat_vec = lo[VEC_W-1:0];
    end else begin
      sat_vec = x[VEC_W-1:0];
    end
  endfunction

  // Product of two Q2.16 values, shifted down with rounding toward minus infinity.
  function automatic logic signed [WIDE_W-1:0] qshift(input logic [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    s = $signed(p) >>> FRAC;
    qshift = WIDE_W'(s);
  endfunction

endpackage
`default_nettype wire

[rtl/core/vector_refraction.sv]
// Vector refraction: a 47-stage pipeline from incident ray and normal to refracted ray.
//
// Input channel s_*: one transfer carries the incident direction, the surface
// normal (both signed Q2.16) and the refractive index (unsigned Q3.12; values
// below 1.0 are taken as 1.0). Output channel m_*: one transfer carries the
// refracted direction and, in tuser, the total reflection flag; on total
// reflection the direction is zero.
// One item is taken every cycle while the pipeline is not held by a stall.
// The depth is set by the restoring divider (one quotient bit per stage,
// 21 stages) and the square root (one result bit per stage, 17 stages),
// plus the multiply and sum stages around them.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the block is empty and ready right after it.
`default_nettype none
module vector_refraction (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output      logic                        s_tready,
  // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z,
  // index, zero fill
  input  wire logic [vref_pkg::IN_W-1:0]   s_tdata,
  output      logic                        m_tvalid,
  input  wire logic                        m_tready,
  // refracted_x, refracted_y, refracted_z, zero fill
  output      logic [vref_pkg::OUT_W-1:0]  m_tdata,
  // total_reflection
  output      logic                        m_tuser
);
  import vref_pkg::*;

  `include "assert_macros.svh"

  item_t            st  [NST];
  item_t            nxt [NST];
  logic [NST-1:0]   vld;
  logic             adv;

  assign adv      = !vld[NST-1] || m_tready;
  assign s_tready = adv;

  always_comb begin
    item_t                    cur;
    logic signed [WIDE_W-1:0] acc;
    logic signed [WIDE_W-1:0] u;
    logic [QUO_W-1:0]         mag;
    logic [REM_W:0]           dtmp;
    logic [SREM_W+1:0]        stmp;
    logic [SREM_W+1:0]        trial;
    logic [QUO_W-1:0]         qbit;
    cur   = '0;
    acc   = '0;
    u     = '0;
    mag   = '0;
    dtmp  = '0;
    stmp  = '0;
    trial = '0;
    qbit  = '0;
    for (int j = 0; j < NST; j++) begin
      if (j == 0) begin
        cur = '0;
        for (int c = 0; c < 3; c++) begin
          cur.iv[c] = s_tdata[c*VEC_W +: VEC_W];
          cur.nv[c] = s_tdata[(c+3)*VEC_W +: VEC_W];
        end
        cur.k = s_tdata[6*VEC_W +: IDX_W];
        if (cur.k < IDX_ONE) begin
          cur.k = IDX_ONE;
        end
      end else begin
        cur = st[j-1];
      end

      if (j == ST_PROD_IN) begin
        for (int c = 0; c < 3; c++) begin
          cur.prod[c] = PROD_W'($signed(cur.iv[c]) * $signed(cur.nv[c]));
        end
      end else if (j == ST_DOT) begin
        acc = qshift(cur.prod[0]) + qshift(cur.prod[1]) + qshift(cur.prod[2]);
        cur.d = sat_vec(acc);
      end else if (j == ST_PROD_D) begin
        for (int c = 0; c < 3; c++) begin
          cur.prod[c] = PROD_W'($signed(cur.d) * $signed(cur.nv[c]));
        end
      end else if (j == ST_DIV_SET) begin
        for (int c = 0; c < 3; c++) begin
          u = WIDE_W'($signed(cur.iv[c])) - qshift(cur.prod[c]);
          cur.neg[c] = u[WIDE_W-1];
          mag = cur.neg[c] ? QUO_W'(-u) : QUO_W'(u);
          // Numerator is mag << 12; its top part is already below the index.
          cur.rem[c] = REM_W'(mag[QUO_W-1:9]);
          cur.num[c] = {mag[8:0], 12'd0};
          cur.quo[c] = '0;
        end
      end else if (j >= ST_DIV0 && j < ST_TVAL) begin
        for (int c = 0; c < 3; c++) begin
          dtmp = {cur.rem[c], cur.num[c][QUO_W-1]};
          qbit = '0;
          if (dtmp >= {1'b0, cur.k}) begin
            dtmp    = dtmp - {1'b0, cur.k};
            qbit[0] = 1'b1;
          end
          cur.rem[c] = dtmp[REM_W-1:0];
          cur.num[c] = {cur.num[c][QUO_W-2:0], 1'b0};
          cur.quo[c] = {cur.quo[c][QUO_W-2:0], qbit[0]};
        end
      end else if (j == ST_TVAL) begin
        for (int c = 0; c < 3; c++) begin
          acc = $signed({3'b000, cur.quo[c]});
          if (cur.neg[c]) begin
            acc = -acc;
          end
          cur.t[c] = sat_vec(acc);
        end
      end else if (j == ST_PROD_T) begin
        for (int c = 0; c < 3; c++) begin
          cur.prod[c] = PROD_W'($signed(cur.t[c]) * $signed(cur.t[c]));
        end
      end else if (j == ST_RAD) begin
        acc = ONE_Q - (qshift(cur.prod[0]) + qshift(cur.prod[1]) + qshift(cur.prod[2]));
        cur.tir  = acc[WIDE_W-1];
        cur.rad  = {1'b0, acc[ROOT_W-1:0], 16'd0};
        cur.srem = '0;
        cur.root = '0;
      end else if (j >= ST_SQ0 && j < ST_PROD_Q) begin
        stmp  = {cur.srem, cur.rad[RAD_W-1 -: 2]};
        trial = {1'b0, cur.root, 2'b01};
        if (stmp >= trial) begin
          stmp     = stmp - trial;
          cur.root = {cur.root[ROOT_W-2:0], 1'b1};
        end else begin
          cur.root = {cur.root[ROOT_W-2:0], 1'b0};
        end
        cur.srem = stmp[SREM_W-1:0];
        cur.rad  = {cur.rad[RAD_W-3:0], 2'b00};
      end else if (j == ST_PROD_Q) begin
        for (int c = 0; c < 3; c++) begin
          cur.prod[c] = PROD_W'($signed({1'b0, cur.root}) * $signed(cur.nv[c]));
        end
      end else if (j == ST_OUT) begin
        for (int c = 0; c < 3; c++) begin
          acc = WIDE_W'($signed(cur.t[c])) - qshift(cur.prod[c]);
          cur.t[c] = cur.tir ? '0 : sat_vec(acc);
        end
      end
      nxt[j] = cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NST; j++) begin
        st[j] <= nxt[j];
      end
    end
  end

  assign m_tvalid = vld[NST-1];
  assign m_tdata  = {2'b00, st[NST-1].t[2], st[NST-1].t[1], st[NST-1].t[0]};
  assign m_tuser  = st[NST-1].tir;

  `ASSERT_IMPL(a_tir_zero, clk, rst, m_tvalid && m_tuser, m_tdata == '0)
  `ASSERT_NEXT(a_enter, clk, rst, s_tvalid && s_tready, vld[0])
  `ASSERT_NEXT(a_hold, clk, rst, !adv, $stable(vld))

endmodule
`default_nettype wire
